/* sv/alasd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the array list block (append, search, delete).
// No dependencies; imported by every module of the block.
package alasd_pkg;

    // Fixed field widths of the transfer payloads
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int OCC_W   = 5;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Source of the reported position
    typedef enum logic [1:0] {
        POS_ZERO = 2'd0,
        POS_FILL = 2'd1,
        POS_HIT  = 2'd2
    } pos_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DISPATCH = 3'd1,
        ST_SCAN     = 3'd2,
        ST_SHIFT    = 3'd3,
        ST_DONE     = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [OCC_W-1:0]   occupancy;
    } out_item_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;        // capture the accepted input item
        logic       append_wr;   // store value at fill index, bump the count
        logic       ptr_clear;   // restart the walk at entry zero
        logic       ptr_set_hit; // start the shift one past the hit
        logic       rd_issue;    // read entry at pointer, advance pointer
        logic       shift_wr;    // move the last read entry down by one
        logic       fill_dec;    // drop one from the count
        logic       res_wr;      // capture status and position
        status_t    res_status;
        pos_sel_t   res_pos_sel;
        logic       out_load;    // move the result into the output register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        kind_t  kind;
        logic   full;
        logic   empty;
        logic   hit;
        logic   ptr_end;
        logic   rd_vld;
        logic   out_busy;
    } dp_stat_t;

endpackage

/* sv/alasd_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the array list: sequences append, scan and shift.
// Depends on alasd_pkg; drives the datapath alasd_dp through dp_cmd_t.
module alasd_ctrl
    import alasd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dp_stat_t    stat,
    output dp_cmd_t     cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                cmd.res_wr = 1'b1;
                unique case (stat.kind)
                    KIND_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status  = STAT_FULL;
                            cmd.res_pos_sel = POS_ZERO;
                        end
                        else
                        begin
                            cmd.append_wr   = 1'b1;
                            cmd.res_status  = STAT_OK;
                            cmd.res_pos_sel = POS_FILL;
                        end
                        state_next = ST_DONE;
                    end
                    KIND_SEARCH, KIND_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status  = STAT_EMPTY;
                            cmd.res_pos_sel = POS_ZERO;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            cmd.res_wr    = 1'b0;
                            cmd.ptr_clear = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused kind: report the count, leave the store alone
                        cmd.res_status  = STAT_OK;
                        cmd.res_pos_sel = POS_ZERO;
                        state_next      = ST_DONE;
                    end
                endcase
            end

            // Walk the entries, one read issued and one compare per cycle
            ST_SCAN:
            begin
                priority if (stat.hit)
                begin
                    cmd.res_wr      = 1'b1;
                    cmd.res_status  = STAT_OK;
                    cmd.res_pos_sel = POS_HIT;
                    if (stat.kind == KIND_DELETE)
                    begin
                        cmd.ptr_set_hit = 1'b1;
                        state_next      = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (stat.ptr_end)
                begin
                    cmd.res_wr      = 1'b1;
                    cmd.res_status  = STAT_NOT_FOUND;
                    cmd.res_pos_sel = POS_ZERO;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end

            // Close the gap: read entry i+1 while writing entry i
            ST_SHIFT:
            begin
                cmd.shift_wr = stat.rd_vld;
                if (stat.ptr_end)
                begin
                    cmd.fill_dec = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end

            // Hold the result until the output register is free
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/alasd_dp.sv */
`timescale 1ns / 1ps
// Datapath for the array list: entry memory, count, capacity, walk pointer, result.
// Depends on alasd_pkg; commanded by alasd_ctrl through dp_cmd_t.
module alasd_dp
    import alasd_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  in_item_t            in_item,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [VALUE_W-1:0] entries_mem [DEPTH];

    in_item_t           item_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      ptr_next;
    logic [IW-1:0]      idx_reg;
    logic               rd_vld_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    status_t            res_status_reg;
    logic [POS_W-1:0]   res_pos_reg;
    logic [POS_W-1:0]   res_pos_next;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Entry count and walk pointer
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.append_wr)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - CW'(1);
        end

        ptr_next = ptr_reg;
        priority if (cmd.ptr_clear)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_set_hit)
        begin
            ptr_next = CW'(idx_reg) + CW'(1);
        end
        else if (cmd.rd_issue)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= cmd.rd_issue;
        end
    end

    // Entry memory: one write port, one registered read port
    assign mem_we    = cmd.append_wr | cmd.shift_wr;
    assign mem_waddr = cmd.append_wr ? fill_reg[IW-1:0] : (idx_reg - IW'(1));
    assign mem_wdata = cmd.append_wr ? $unsigned(item_reg.value) : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= entries_mem[ptr_reg[IW-1:0]];
            idx_reg     <= ptr_reg[IW-1:0];
        end
    end

    // Result capture
    always_comb
    begin
        unique case (cmd.res_pos_sel)
            POS_FILL: res_pos_next = POS_W'(fill_reg);
            POS_HIT:  res_pos_next = POS_W'(idx_reg);
            default:  res_pos_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_wr)
        begin
            res_status_reg <= cmd.res_status;
            res_pos_reg    <= res_pos_next;
        end
    end

    // Output register: load when free, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.out_load | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.status    <= res_status_reg;
            out_item_reg.position  <= res_pos_reg;
            out_item_reg.occupancy <= OCC_W'(fill_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Status to the controller
    always_comb
    begin
        stat.kind     = item_reg.kind;
        stat.full     = (EW'(fill_reg) >= EW'(cap_reg)) || (EW'(fill_reg) >= EW'(DEPTH));
        stat.empty    = (fill_reg == '0);
        stat.hit      = rd_vld_reg && (rd_data_reg == $unsigned(item_reg.value));
        stat.ptr_end  = (ptr_reg >= fill_reg);
        stat.rd_vld   = rd_vld_reg;
        stat.out_busy = out_valid_reg & out_stall;
    end

endmodule

/* sv/array_list_append_search_delete_top.sv */
`timescale 1ns / 1ps
// Top level of the array list block: controller plus datapath.
// Depends on alasd_pkg, alasd_ctrl and alasd_dp.
//
//   channel  signals                         moves
//   in       in_valid / in_stall / in_item   one operation (kind, value)
//   out      out_valid / out_stall / out_item one result (status, position, occupancy)
//   cfg      cfg_wr_en / cfg_wr_data         capacity register, no wait
//
// Append or an unused kind passes from DISPATCH to DONE and then into the output register.
// Search walks the entries up to the first hit; a miss walks all stored entries.
// Delete walks to the hit, then shifts the later entries, one per cycle.
// The single read port of the entry memory sets the one-entry-per-cycle pace.
// Reset clears the count and restores capacity to 16; entries are not cleared.
// A stalled result holds in the output register; the next item is taken meanwhile.
module array_list_append_search_delete_top
    import alasd_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    alasd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result path
    alasd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

/* sv/alasd_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the array list block, bound to its top level.
// Depends on alasd_pkg and array_list_append_search_delete_top.
module alasd_chk
    import alasd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_item
);

    // Hold off the next item while one is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in work");

    // A failed operation reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != STAT_OK) |-> (out_item.position == '0))
        else $error("nonzero position on a failed operation");

    // Empty store reports zero occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status == STAT_EMPTY) |-> (out_item.occupancy == '0))
        else $error("empty status with nonzero occupancy");

    // A new result leaves the block ready for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("block not ready after issuing a result");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed or dropped");

endmodule

bind array_list_append_search_delete_top alasd_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

/* dv/array_list_append_search_delete_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the array list block: a queue-fed driver, a result monitor
// and a predictor of the stored list. Depends on alasd_pkg and array_list_append_search_delete_top.
module array_list_append_search_delete_top_tb;
    import alasd_pkg::*;

    localparam int DEPTH       = 16;
    localparam int N_PHASES    = 8;
    localparam int PHASE_OPS   = 200;
    localparam int SETTLE_GAP  = 40;
    localparam int STALL_LIMIT = 4000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_item;
    logic               cfg_wr_en;
    logic [CAP_W-1:0]   cfg_wr_data;

    // Stimulus and scoreboard state
    in_item_t           pending_ops [$];
    out_item_t          expected_results [$];
    bit                 in_taken;
    int                 snd_idle_pct;
    int                 rcv_idle_pct;
    int                 n_pushed;
    int                 n_accepted;
    int                 n_errors;
    int                 n_settings;
    int                 idle_cycles;
    int                 status_seen [4];

    // Shadow of the list and its capacity register
    logic signed [VALUE_W-1:0]  list_entries [DEPTH];
    int                         fill_cnt;
    logic [CAP_W-1:0]           capacity_cfg;

    logic signed [VALUE_W-1:0]  value_pool [6];
    logic [CAP_W-1:0]           phase_caps [N_PHASES] =
        '{5'd31, 5'd3, 5'd16, 5'd0, 5'd7, 5'd1, 5'd12, 5'd16};

    array_list_append_search_delete_top #(
        .DEPTH          (DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    // Run the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one operation to the shadow list and return the result it should give
    function automatic out_item_t predict_list_op(input in_item_t op);
        out_item_t  res;
        int         cap_eff;
        int         hit_idx;
        res.status    = STAT_OK;
        res.position  = '0;
        cap_eff = (int'(capacity_cfg) > DEPTH) ? DEPTH : int'(capacity_cfg);
        hit_idx = -1;
        case (op.kind)
            KIND_APPEND:
            begin
                if (fill_cnt >= cap_eff)
                    res.status = STAT_FULL;
                else
                begin
                    res.position = POS_W'(fill_cnt);
                    list_entries[fill_cnt] = op.value;
                    fill_cnt++;
                end
            end
            KIND_SEARCH, KIND_DELETE:
            begin
                if (fill_cnt == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < fill_cnt; i++)
                        if (hit_idx < 0 && list_entries[i] == op.value)
                            hit_idx = i;
                    if (hit_idx < 0)
                        res.status = STAT_NOT_FOUND;
                    else
                    begin
                        res.position = POS_W'(hit_idx);
                        // close the gap left by the removed entry
                        if (op.kind == KIND_DELETE)
                        begin
                            for (int j = hit_idx; j < fill_cnt - 1; j++)
                                list_entries[j] = list_entries[j + 1];
                            fill_cnt--;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(fill_cnt);
        return res;
    endfunction

    // Check results, predict on accepted operations, and watch for a hang
    always @(posedge clk)
    begin
        out_item_t want;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d position %0d occupancy %0d",
                           out_item.status, out_item.position, out_item.occupancy);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        n_errors++;
                    end
                    if (out_item.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, out_item.position);
                        n_errors++;
                    end
                    if (out_item.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, out_item.occupancy);
                        n_errors++;
                    end
                    status_seen[want.status]++;
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                expected_results.push_back(predict_list_op(in_item));
                n_accepted++;
                in_taken = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d results outstanding",
                       idle_cycles, expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Drive operations and result back-pressure at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
            // hold a stalled transfer, otherwise offer the next one or idle
            if (!in_valid || in_taken)
            begin
                in_taken = 1'b0;
                if (pending_ops.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    in_item  <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic push_op(input kind_t kind, input logic signed [VALUE_W-1:0] value);
        in_item_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        n_pushed++;
    endtask

    // Wait until every queued operation is taken and answered, then let the block settle
    task automatic drain_results();
        while (n_accepted != n_pushed || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_cfg = cap;
        n_settings++;
    endtask

    // Mostly values from a small pool so searches and deletes hit, some fully random
    function automatic in_item_t random_op();
        in_item_t op;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 40)
            op.kind = KIND_APPEND;
        else if (pick < 65)
            op.kind = KIND_SEARCH;
        else if (pick < 95)
            op.kind = KIND_DELETE;
        else
            op.kind = KIND_NONE;
        if ($urandom_range(99) < 75)
            op.value = value_pool[$urandom_range(5)];
        else
            op.value = $urandom;
        return op;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        out_stall    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_taken     = 1'b0;
        snd_idle_pct = 32;
        rcv_idle_pct = 81;
        n_pushed     = 0;
        n_accepted   = 0;
        n_errors     = 0;
        n_settings   = 0;
        idle_cycles  = 0;
        fill_cnt     = 0;
        capacity_cfg = CAP_RESET;
        for (int s = 0; s < 4; s++)
            status_seen[s] = 0;
        for (int i = 0; i < DEPTH; i++)
            list_entries[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty store, unused kind, extremes, duplicates, first match, shifting deletes
        push_op(KIND_SEARCH, 32'sd0);
        push_op(KIND_DELETE, 32'sd0);
        push_op(KIND_NONE, 32'sd0);
        push_op(KIND_APPEND, 32'sh8000_0000);
        push_op(KIND_APPEND, 32'sh7fff_ffff);
        push_op(KIND_APPEND, 32'sd0);
        push_op(KIND_APPEND, -32'sd1);
        push_op(KIND_APPEND, 32'sd5);
        push_op(KIND_APPEND, 32'sd5);
        push_op(KIND_SEARCH, 32'sd5);
        push_op(KIND_SEARCH, 32'sh7fff_ffff);
        push_op(KIND_SEARCH, 32'sd7);
        push_op(KIND_DELETE, 32'sh8000_0000);
        push_op(KIND_DELETE, 32'sd5);
        push_op(KIND_DELETE, -32'sd1);
        push_op(KIND_NONE, -32'sd1);
        drain_results();

        // Capacity lowered below the fill: appends refuse, the rest still sees all entries
        set_capacity(5'd1);
        push_op(KIND_APPEND, 32'sd9);
        push_op(KIND_SEARCH, 32'sd5);
        push_op(KIND_DELETE, 32'sh7fff_ffff);
        drain_results();

        // Zero capacity, then empty the store through its last entry
        set_capacity(5'd0);
        push_op(KIND_APPEND, 32'sd1);
        push_op(KIND_DELETE, 32'sd0);
        push_op(KIND_SEARCH, 32'sd0);
        push_op(KIND_DELETE, 32'sd5);
        drain_results();

        // Random phases over several capacities and idle profiles
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            if (p < 3)
            begin
                snd_idle_pct = 32;
                rcv_idle_pct = 81;
            end
            else if (p < 6)
            begin
                snd_idle_pct = 81;
                rcv_idle_pct = 32;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            for (int k = 0; k < 6; k++)
                value_pool[k] = $urandom;
            if (p % 2 == 0)
            begin
                value_pool[0] = 32'sh8000_0000;
                value_pool[1] = 32'sh7fff_ffff;
            end
            for (int n = 0; n < PHASE_OPS; n++)
                pending_ops.push_back(random_op());
            n_pushed += PHASE_OPS;
            drain_results();
        end

        $display("Ran %0d operations over %0d capacity settings with varied idling.",
                 n_accepted, n_settings);
        $display("Results seen: %0d ok, %0d full, %0d empty, %0d not found.",
                 status_seen[STAT_OK], status_seen[STAT_FULL],
                 status_seen[STAT_EMPTY], status_seen[STAT_NOT_FOUND]);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* array_list_append_search_delete_top.f */
sv/alasd_pkg.sv
sv/alasd_ctrl.sv
sv/alasd_dp.sv
sv/array_list_append_search_delete_top.sv
sv/alasd_chk.sv
dv/array_list_append_search_delete_top_tb.sv
